@@ rtl/bup2_pkg.sv @@
// Shared types, constants and the channel averaging function for the
// bilinear 2x upscaler. No dependencies.
`default_nettype none

package bup2_pkg;

   localparam int MAX_WIDTH   = 64;
   localparam int MAX_HEIGHT  = 1024;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int PIX_W       = 24;
   localparam int IMG_WIDTH_W  = 7;
   localparam int IMG_HEIGHT_W = 11;
   localparam int CSR_DATA_W  = 11;
   localparam int RSP_DATA_W  = 48;

   localparam logic [IMG_WIDTH_W-1:0]  WIDTH_RESET  = 7'd28;
   localparam logic [IMG_HEIGHT_W-1:0] HEIGHT_RESET = 11'd28;
   localparam logic [IMG_WIDTH_W-1:0]  WIDTH_MIN    = 7'd2;
   localparam logic [IMG_WIDTH_W-1:0]  WIDTH_MAX    = 7'd64;
   localparam logic [IMG_HEIGHT_W-1:0] HEIGHT_MIN   = 11'd2;
   localparam logic [IMG_HEIGHT_W-1:0] HEIGHT_MAX   = 11'd1024;

   typedef enum logic [1:0] {
      CSR_IMG_WIDTH  = 2'd0,
      CSR_IMG_HEIGHT = 2'd1
   } csr_index_type;

   typedef logic [PIX_W-1:0] pixel_type;

   // Rounded mean of four pixels, per 8-bit channel. Two-point and copy
   // cases are formed by repeating operands.
   function automatic pixel_type avg4(input pixel_type a, input pixel_type b,
                                      input pixel_type d, input pixel_type e);
      pixel_type  r;
      logic [9:0] s;
      for (int c = 0; c < 3; c++) begin
         s = 10'(a[8*c +: 8]) + 10'(b[8*c +: 8]) + 10'(d[8*c +: 8])
           + 10'(e[8*c +: 8]) + 10'd2;
         r[8*c +: 8] = s[9:2];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/bilinear_upscale_by_two_unit.sv @@
// Top level of the bilinear 2x upscaler: line store, pixel context
// registers, block sequencer and output register. Uses bup2_pkg.
`default_nettype none

//  Channel   Direction  Handshake             Payload
//  req_      in         req_tvalid/tready     tdata[23:0] pixel_rgb
//  rsp_      out        rsp_tvalid/tready     tdata rgb/col/row, tlast, tuser
//  csr_      in         csr_valid/ready       csr_index, csr_data
//
// An item completes 4 output pixels in the interior, 8 or 16 on the right
// column and bottom row, and none in the first row or column. The output
// sequencer emits one pixel per cycle while the output register can load,
// and stage 1 takes new items while it works. The line store is read when
// an item is accepted and written one stage later. Reset is synchronous and
// clears counters, context pixels and valid flags; the line store is not
// cleared since row 0 always fills it first. Both sides may stall freely.
module bilinear_upscale_by_two_unit
   import bup2_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [PIX_W-1:0]      req_tdata,   // [23:0] pixel_rgb
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,   // [23:0] out_rgb, [30:24] out_col,
                                                   // [41:31] out_row, [47:42] zero
   output      logic                  rsp_tlast,   // run_last
   output      logic                  rsp_tuser,   // frame_end
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [1:0]            csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   // Configuration and frame position.
   logic [IMG_WIDTH_W-1:0]  img_width_ff;
   logic [IMG_HEIGHT_W-1:0] img_height_ff;
   logic [COL_W-1:0]        col_count_ff;
   logic [ROW_W-1:0]        row_count_ff;
   logic [IMG_WIDTH_W-1:0]  w_eff;
   logic [IMG_HEIGHT_W-1:0] h_eff;
   logic                    cur_last_col;
   logic                    cur_last_row;
   logic                    restart;

   // Line store.
   pixel_type               row_store [MAX_WIDTH];
   pixel_type               above_ff;

   // Stage 1: line store read in flight.
   logic                    s1_valid_ff;
   pixel_type               s1_px_ff;
   logic [COL_W-1:0]        s1_x_ff;
   logic [ROW_W-1:0]        s1_y_ff;
   logic                    s1_last_col_ff;
   logic                    s1_last_row_ff;
   logic [3:0]              s1_mask;
   logic                    s1_move;

   // Left context pixels.
   pixel_type               left_cur_ff;
   pixel_type               left_prev_ff;

   // Stage 2: block sequencer. Mask bits: main, right edge, bottom, corner.
   logic [3:0]              s2_mask_ff;
   logic [3:0]              s2_mask_in;
   logic [1:0]              s2_sub_ff;
   pixel_type               s2_px_ff;
   pixel_type               s2_above_ff;
   pixel_type               s2_aleft_ff;
   pixel_type               s2_left_ff;
   logic [COL_W-1:0]        s2_x_ff;
   logic [ROW_W-1:0]        s2_y_ff;
   logic                    s2_corner_ff;
   logic                    s2_emit;
   logic                    s2_last_out;
   logic                    s2_free;
   logic                    s2_load;

   // Current block operands.
   pixel_type               blk_a, blk_b, blk_d, blk_e;
   pixel_type               op_a, op_b, op_d, op_e;
   logic [COL_W-1:0]        blk_x;
   logic [ROW_W-1:0]        blk_y;

   // Output register.
   logic                    rsp_valid_ff;
   pixel_type               rsp_rgb_ff;
   logic [COL_W:0]          rsp_col_ff;
   logic [ROW_W:0]          rsp_row_ff;
   logic                    rsp_last_ff;
   logic                    rsp_end_ff;
   logic                    out_load;

   logic                    req_accept;

   always_comb begin
      if (img_width_ff < WIDTH_MIN) begin
         w_eff = WIDTH_MIN;
      end else if (img_width_ff > WIDTH_MAX) begin
         w_eff = WIDTH_MAX;
      end else begin
         w_eff = img_width_ff;
      end
      if (img_height_ff < HEIGHT_MIN) begin
         h_eff = HEIGHT_MIN;
      end else if (img_height_ff > HEIGHT_MAX) begin
         h_eff = HEIGHT_MAX;
      end else begin
         h_eff = img_height_ff;
      end
   end

   assign cur_last_col = ({1'b0, col_count_ff} == (w_eff - 7'd1));
   assign cur_last_row = ({1'b0, row_count_ff} == (h_eff - 11'd1));

   assign csr_ready  = 1'b1;
   assign restart    = csr_valid && csr_ready
                       && ((csr_index == CSR_IMG_WIDTH) || (csr_index == CSR_IMG_HEIGHT));

   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign s2_emit    = (s2_mask_ff != 4'd0) && out_load;
   assign s2_last_out = (s2_sub_ff == 2'd3) && ((s2_mask_ff & (s2_mask_ff - 4'd1)) == 4'd0);
   assign s2_free    = (s2_mask_ff == 4'd0) || (s2_emit && s2_last_out);

   assign s1_mask[0] = (s1_y_ff != '0) && (s1_x_ff != '0);
   assign s1_mask[1] = (s1_y_ff != '0) && s1_last_col_ff;
   assign s1_mask[2] = s1_last_row_ff && (s1_x_ff != '0);
   assign s1_mask[3] = s1_last_row_ff && s1_last_col_ff;
   // An item that completes nothing retires without entering the sequencer.
   assign s1_move    = s1_valid_ff && ((s1_mask == 4'd0) || s2_free);
   assign s2_load    = s1_move && (s1_mask != 4'd0);

   assign req_tready = !s1_valid_ff || s1_move;
   assign req_accept = req_tvalid && req_tready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         img_width_ff  <= WIDTH_RESET;
         img_height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IMG_WIDTH:  img_width_ff  <= csr_data[IMG_WIDTH_W-1:0];
            CSR_IMG_HEIGHT: img_height_ff <= csr_data;
            default:        ;
         endcase
      end
   end

   // Frame position advances on each accepted item.
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else if (req_accept) begin
         if (cur_last_col) begin
            col_count_ff <= '0;
            row_count_ff <= cur_last_row ? '0 : row_count_ff + 10'd1;
         end else begin
            col_count_ff <= col_count_ff + 6'd1;
         end
      end
   end

   // Line store: read on accept, written as the item leaves stage 1. The
   // next item always reads another column, so the read data is never stale.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         above_ff <= row_store[col_count_ff];
      end
      if (s1_move) begin
         row_store[s1_x_ff] <= s1_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_px_ff       <= req_tdata;
         s1_x_ff        <= col_count_ff;
         s1_y_ff        <= row_count_ff;
         s1_last_col_ff <= cur_last_col;
         s1_last_row_ff <= cur_last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         left_cur_ff  <= '0;
         left_prev_ff <= '0;
      end else if (s1_move) begin
         left_cur_ff  <= s1_last_col_ff ? '0 : s1_px_ff;
         left_prev_ff <= s1_last_col_ff ? '0 : above_ff;
      end
   end

   // Sequencer: walk the present blocks, four outputs each.
   always_comb begin
      s2_mask_in = s2_mask_ff;
      if (s2_load) begin
         s2_mask_in = s1_mask;
      end else if (s2_emit && (s2_sub_ff == 2'd3)) begin
         s2_mask_in = s2_mask_ff & (s2_mask_ff - 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_mask_ff <= '0;
         s2_sub_ff  <= '0;
      end else begin
         s2_mask_ff <= s2_mask_in;
         if (s2_load) begin
            s2_sub_ff <= '0;
         end else if (s2_emit) begin
            s2_sub_ff <= s2_sub_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_px_ff     <= s1_px_ff;
         s2_above_ff  <= above_ff;
         s2_aleft_ff  <= left_prev_ff;
         s2_left_ff   <= left_cur_ff;
         s2_x_ff      <= s1_x_ff;
         s2_y_ff      <= s1_y_ff;
         s2_corner_ff <= s1_last_col_ff && s1_last_row_ff;
      end
   end

   // Lowest pending block sets the neighbours and the input coordinates.
   always_comb begin
      if (s2_mask_ff[0]) begin
         blk_a = s2_aleft_ff;
         blk_b = s2_above_ff;
         blk_d = s2_left_ff;
         blk_e = s2_px_ff;
         blk_x = s2_x_ff - 6'd1;
         blk_y = s2_y_ff - 10'd1;
      end else if (s2_mask_ff[1]) begin
         blk_a = s2_above_ff;
         blk_b = s2_above_ff;
         blk_d = s2_px_ff;
         blk_e = s2_px_ff;
         blk_x = s2_x_ff;
         blk_y = s2_y_ff - 10'd1;
      end else if (s2_mask_ff[2]) begin
         blk_a = s2_left_ff;
         blk_b = s2_px_ff;
         blk_d = s2_left_ff;
         blk_e = s2_px_ff;
         blk_x = s2_x_ff - 6'd1;
         blk_y = s2_y_ff;
      end else begin
         blk_a = s2_px_ff;
         blk_b = s2_px_ff;
         blk_d = s2_px_ff;
         blk_e = s2_px_ff;
         blk_x = s2_x_ff;
         blk_y = s2_y_ff;
      end
   end

   // Copy and two-point means reuse the four-point adder with repeated operands.
   always_comb begin
      case (s2_sub_ff)
         2'd0: begin
            op_a = blk_a; op_b = blk_a; op_d = blk_a; op_e = blk_a;
         end
         2'd1: begin
            op_a = blk_a; op_b = blk_a; op_d = blk_b; op_e = blk_b;
         end
         2'd2: begin
            op_a = blk_a; op_b = blk_a; op_d = blk_d; op_e = blk_d;
         end
         default: begin
            op_a = blk_a; op_b = blk_b; op_d = blk_d; op_e = blk_e;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= s2_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_emit) begin
         rsp_rgb_ff  <= avg4(op_a, op_b, op_d, op_e);
         rsp_col_ff  <= {blk_x, s2_sub_ff[0]};
         rsp_row_ff  <= {blk_y, s2_sub_ff[1]};
         rsp_last_ff <= s2_last_out;
         rsp_end_ff  <= s2_last_out && s2_corner_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_row_ff, rsp_col_ff, rsp_rgb_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_end_ff;

endmodule

`default_nettype wire

@@ dv/bilinear_upscale_by_two_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for bilinear_upscale_by_two_unit: streams pixels under
// several geometries, predicts every upscaled output pixel and compares them in order.
// Depends on bup2_pkg and the RTL of the block.

module bilinear_upscale_by_two_unit_test;
   import bup2_pkg::*;

   // Indexes past the register list; a write there must leave the frame alone.
   localparam logic [1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [1:0] CSR_SPARE_3 = 2'd3;
   localparam int SETTLE_CYCLES   = 24;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int MAX_PRINTED     = 40;

   typedef struct packed {
      pixel_type   rgb;
      logic [6:0]  col;
      logic [10:0] row;
      logic        run_last;
      logic        frame_end;
   } out_pixel_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [1:0]            csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int idle_pct      = 0;
   int stall_pct     = 0;
   int hold_off_left = 0;
   int mismatch_count = 0;

   // Predicted block state and configuration.
   logic [IMG_WIDTH_W-1:0]  width_cfg  = WIDTH_RESET;
   logic [IMG_HEIGHT_W-1:0] height_cfg = HEIGHT_RESET;
   pixel_type line_store [MAX_WIDTH];
   pixel_type left_cur  = '0;
   pixel_type left_prev = '0;
   int col_pos = 0;
   int row_pos = 0;

   out_pixel_type upscaled_pixels [$];

   bilinear_upscale_by_two_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int active_width();
      if (width_cfg < WIDTH_MIN) return int'(WIDTH_MIN);
      if (width_cfg > WIDTH_MAX) return int'(WIDTH_MAX);
      return int'(width_cfg);
   endfunction

   function automatic int active_height();
      if (height_cfg < HEIGHT_MIN) return int'(HEIGHT_MIN);
      if (height_cfg > HEIGHT_MAX) return int'(HEIGHT_MAX);
      return int'(height_cfg);
   endfunction

   function automatic pixel_type mean2(input pixel_type a, input pixel_type b);
      pixel_type r;
      int s;
      for (int c = 0; c < 3; c++) begin
         s = int'(a[8*c +: 8]) + int'(b[8*c +: 8]) + 1;
         r[8*c +: 8] = 8'(s >> 1);
      end
      return r;
   endfunction

   function automatic pixel_type mean4(input pixel_type a, input pixel_type b,
                                       input pixel_type d, input pixel_type e);
      pixel_type r;
      int s;
      for (int c = 0; c < 3; c++) begin
         s = int'(a[8*c +: 8]) + int'(b[8*c +: 8]) + int'(d[8*c +: 8])
           + int'(e[8*c +: 8]) + 2;
         r[8*c +: 8] = 8'(s >> 2);
      end
      return r;
   endfunction

   // Queues the 2x2 output block whose top-left input pixel sits at (bx, by).
   function automatic void add_block(input pixel_type a, input pixel_type b,
                                     input pixel_type d, input pixel_type e,
                                     input int bx, input int by,
                                     input logic tail, input logic fend);
      upscaled_pixels.push_back('{a, 7'(2*bx), 11'(2*by), 1'b0, 1'b0});
      upscaled_pixels.push_back('{mean2(a, b), 7'(2*bx + 1), 11'(2*by), 1'b0, 1'b0});
      upscaled_pixels.push_back('{mean2(a, d), 7'(2*bx), 11'(2*by + 1), 1'b0, 1'b0});
      upscaled_pixels.push_back('{mean4(a, b, d, e), 7'(2*bx + 1), 11'(2*by + 1),
                                  tail, fend});
   endfunction

   function automatic void upscale_pixel(input pixel_type px);
      int w, h, x, y;
      pixel_type above, above_left, left;
      logic last_col, last_row, blk_a, blk_b, blk_c, blk_d;
      w = active_width();
      h = active_height();
      x = (col_pos >= w) ? w - 1 : col_pos;
      y = (row_pos >= h) ? h - 1 : row_pos;
      above      = line_store[COL_W'(x)];
      above_left = left_prev;
      left       = left_cur;
      last_col   = (x == w - 1);
      last_row   = (y == h - 1);
      blk_a = (y >= 1) && (x >= 1);
      blk_b = (y >= 1) && last_col;
      blk_c = last_row && (x >= 1);
      blk_d = last_row && last_col;
      // The last block queued for a pixel carries tlast; the corner block ends the frame.
      if (blk_a) add_block(above_left, above, left, px, x - 1, y - 1,
                           !(blk_b || blk_c || blk_d), 1'b0);
      if (blk_b) add_block(above, above, px, px, x, y - 1, !(blk_c || blk_d), 1'b0);
      if (blk_c) add_block(left, px, left, px, x - 1, y, !blk_d, 1'b0);
      if (blk_d) add_block(px, px, px, px, x, y, 1'b1, 1'b1);

      left_prev = above;
      left_cur  = px;
      line_store[COL_W'(x)] = px;
      if (last_col) begin
         col_pos   = 0;
         left_cur  = '0;
         left_prev = '0;
         row_pos   = last_row ? 0 : y + 1;
      end else begin
         col_pos = x + 1;
         row_pos = y;
      end
   endfunction

   function automatic void restart_frame();
      col_pos   = 0;
      row_pos   = 0;
      left_cur  = '0;
      left_prev = '0;
   endfunction

   function automatic pixel_type rand_pixel();
      pixel_type p;
      for (int c = 0; c < 3; c++) begin
         case ($urandom_range(3))
            0:       p[8*c +: 8] = 8'h00;
            1:       p[8*c +: 8] = 8'hFF;
            default: p[8*c +: 8] = 8'($urandom);
         endcase
      end
      return p;
   endfunction

   // ---------------------------------------------------------------- drivers

   // Leaves req_tvalid high after the handshake so back-to-back items need no gap.
   task automatic send_pixel(input pixel_type px);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      upscale_pixel(px);
   endtask

   // The caller lowers csr_valid once its last write is through.
   task automatic write_reg(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_IMG_WIDTH: begin
            width_cfg = value[IMG_WIDTH_W-1:0];
            restart_frame();
         end
         CSR_IMG_HEIGHT: begin
            height_cfg = value;
            restart_frame();
         end
         default: ;
      endcase
   endtask

   task automatic set_geometry(input int w, input int h);
      write_reg(CSR_IMG_WIDTH, {4'($urandom), 7'(w)});
      write_reg(CSR_IMG_HEIGHT, 11'(h));
      csr_valid <= 1'b0;
   endtask

   // Items in the first row or column produce nothing, so an empty queue alone
   // does not mean the block is idle; a settling wait after the queue empties covers that.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (upscaled_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- response side

   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_tready    <= 1'b0;
         hold_off_left <= hold_off_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < MAX_PRINTED)
         $display("ERROR at %0t ns: %s got %0h expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_output
      out_pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (upscaled_pixels.size() == 0) begin
            report_mismatch("unexpected output pixel", rsp_tdata[31:0], 32'd0);
         end else begin
            want = upscaled_pixels.pop_front();
            if (rsp_tdata[23:0] !== want.rgb)
               report_mismatch("out_rgb", 32'(rsp_tdata[23:0]), 32'(want.rgb));
            if (rsp_tdata[30:24] !== want.col)
               report_mismatch("out_col", 32'(rsp_tdata[30:24]), 32'(want.col));
            if (rsp_tdata[41:31] !== want.row)
               report_mismatch("out_row", 32'(rsp_tdata[41:31]), 32'(want.row));
            if (rsp_tdata[47:42] !== 6'd0)
               report_mismatch("tdata padding", 32'(rsp_tdata[47:42]), 32'd0);
            if (rsp_tlast !== want.run_last)
               report_mismatch("run_last", 32'(rsp_tlast), 32'(want.run_last));
            if (rsp_tuser !== want.frame_end)
               report_mismatch("frame_end", 32'(rsp_tuser), 32'(want.frame_end));
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // Nothing has been written yet, so the reset geometry of 28 x 28 applies.
   task automatic test_reset_geometry();
      idle_pct  = 0;
      stall_pct = 0;
      repeat (62) send_pixel(rand_pixel());
      wait_idle();
   endtask

   task automatic test_directed_corners();
      idle_pct  = 0;
      stall_pct = 0;
      // Width and height of zero clamp up to a 2 x 2 frame.
      set_geometry(0, 0);
      send_pixel(24'hFFFFFF);
      send_pixel(24'h000000);
      send_pixel(24'h000000);
      send_pixel(24'hFFFFFF);
      // The next frame follows without a write; odd sums check rounding half up.
      send_pixel(24'h010101);
      send_pixel(24'h000000);
      send_pixel(24'h000000);
      send_pixel(24'h010300);
      // Writes to indexes past the list must not restart the frame in progress.
      send_pixel(24'h123456);
      send_pixel(24'hABCDEF);
      wait_idle();
      write_reg(CSR_SPARE_2, 11'h7FF);
      write_reg(CSR_SPARE_3, 11'h2AA);
      csr_valid <= 1'b0;
      send_pixel(24'hFEDCBA);
      send_pixel(24'h00FF00);
      wait_idle();
      // A width write mid-frame restarts at row 0, column 0.
      set_geometry(3, 3);
      repeat (4) send_pixel(rand_pixel());
      wait_idle();
      write_reg(CSR_IMG_WIDTH, 11'd3);
      csr_valid <= 1'b0;
      send_pixel(24'hFFFFFF);
      send_pixel(24'h000000);
      send_pixel(24'hFF00FF);
      send_pixel(24'h00FF00);
      send_pixel(24'h7F7F7F);
      send_pixel(24'h808080);
      send_pixel(24'h000001);
      send_pixel(24'hFFFFFE);
      send_pixel(24'h800000);
      wait_idle();
   endtask

   task automatic test_random_frames(input int idle, input int stall, input int n_items);
      int sent, w, h, count;
      idle_pct  = idle;
      stall_pct = stall;
      sent = 0;
      while (sent < n_items) begin
         case ($urandom_range(9))
            0: begin
               w = ($urandom_range(1) != 0) ? MAX_WIDTH : $urandom_range(65, 127);
               h = 2;
            end
            1: begin
               w = $urandom_range(1);
               h = $urandom_range(1);
            end
            2: begin
               w = $urandom_range(2, 4);
               h = ($urandom_range(1) != 0) ? MAX_HEIGHT : $urandom_range(1025, 2047);
            end
            default: begin
               w = $urandom_range(2, 9);
               h = $urandom_range(2, 7);
            end
         endcase
         wait_idle();
         set_geometry(w, h);
         count = active_width() * active_height() * $urandom_range(1, 2);
         // Now and then a frame is cut short so that the next write lands mid-frame;
         // the last frame of the phase is cut to the item budget.
         if ($urandom_range(4) == 0)
            count = $urandom_range(1, count);
         if (count > n_items - sent)
            count = n_items - sent;
         repeat (count) send_pixel(rand_pixel());
         sent += count;
      end
      wait_idle();
   endtask

   // The receiver holds off long enough for the block to fill and stall its input.
   task automatic test_back_pressure();
      idle_pct  = 0;
      stall_pct = 0;
      set_geometry(8, 6);
      hold_off_left <= HOLD_OFF_CYCLES;
      repeat (48) send_pixel(rand_pixel());
      wait_idle();
   endtask

   // Width 127 clamps to 64 columns; run one whole frame and into the next.
   task automatic test_wide_frame();
      idle_pct  = 0;
      stall_pct = 0;
      set_geometry(127, 2);
      repeat (2 * MAX_WIDTH + 4) send_pixel(rand_pixel());
      wait_idle();
   endtask

   initial begin : main
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_IMG_WIDTH;
      csr_data   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_geometry();
      test_directed_corners();
      test_random_frames(0, 0, 40);
      test_random_frames(84, 0, 40);
      test_random_frames(0, 84, 40);
      test_random_frames(6, 6, 40);
      test_back_pressure();
      test_wide_frame();

      if (mismatch_count == 0) begin
         $display("PASS bilinear_upscale_by_two_unit");
      end else begin
         $display("FAIL bilinear_upscale_by_two_unit");
      end
      $finish;
   end

   initial begin : watchdog
      #40_000_000;
      $display("FAIL bilinear_upscale_by_two_unit");
      $finish;
   end

endmodule
